### design/circle_raster_canvas_assert.svh
// assertion macros for the circle raster canvas
// expects clk and rst_n in the scope of the including module
`ifndef CIRCLE_RASTER_CANVAS_ASSERT_SVH
`define CIRCLE_RASTER_CANVAS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/crc_pkg.sv
// shared types, codes and constants of the circle raster canvas
// used by every module of the block; depends on nothing
package crc_pkg;

    // canvas geometry, cell address is {row, col}
    localparam int MAX_SIDE = 512;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int SIZE_W   = SIDE_W + 1;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = 2 * SIDE_W;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int COORD_W  = 20;
    localparam int FRAC_W   = 8;
    localparam int READ_W   = 9;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int MUL_W    = COORD_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_W     = 40;
    localparam int STEP_W   = 32;

    // fixed point constants
    localparam int UNIT        = 1 << FRAC_W;
    localparam int SQ_STEP0    = UNIT * UNIT;
    localparam int SQ_STEP_INC = 2 * UNIT * UNIT;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RADIUS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1);
    localparam logic [CHAR_W-1:0] RESET_BG     = CHAR_W'(32);

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic                      outline_only;
        logic [CHAR_W-1:0]         paint_char;
        logic [READ_W-1:0]         read_col;
        logic [READ_W-1:0]         read_row;
    } crc_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [STAT_W-1:0] status;
    } crc_rsp_t;

    typedef struct packed {
        logic [SIZE_W-1:0] canvas_width;
        logic [SIZE_W-1:0] canvas_height;
        logic [CHAR_W-1:0] background_char;
    } crc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CX,
        ST_MUL_CY,
        ST_MUL_R,
        ST_MUL_RI,
        ST_SCAN,
        ST_DRAIN,
        ST_READ,
        ST_READ_DONE
    } crc_state_t;

    typedef enum logic [1:0] {
        MUL_CX,
        MUL_CY,
        MUL_R,
        MUL_RI
    } crc_mul_sel_t;

    // sequencer to distance unit
    typedef struct packed {
        logic              mul_en;
        crc_mul_sel_t      mul_sel;
        logic              scan_init;
        logic              emit;
        logic              col_step;
        logic              row_step;
        logic              fill_all;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] row;
        logic [CHAR_W-1:0] paint_char;
    } crc_ctl_t;

    // canvas write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } crc_wr_t;

    // columns or rows in use, clamped to the canvas side
    function automatic logic [SIZE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = (v > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : v;
        return r;
    endfunction

endpackage

### design/crc_canvas_ram.sv
// canvas memory: one write port, one read port with registered data
// depends on crc_pkg
module crc_canvas_ram (
    input  logic                         clk,
    input  crc_pkg::crc_wr_t             wr,
    input  logic                         rd_en,
    input  logic [crc_pkg::ADDR_W-1:0]   rd_addr,
    output logic [crc_pkg::CHAR_W-1:0]   rd_data
);

    logic [crc_pkg::CHAR_W-1:0] mem [crc_pkg::DEPTH];
    logic [crc_pkg::CHAR_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/crc_dist.sv
// distance unit: setup squares on one shared multiplier, incremental
// squared distance per cell, disc and ring test, canvas write request
// depends on crc_pkg
module crc_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  crc_pkg::crc_ctl_t ctl,
    input  crc_pkg::crc_req_t req,
    output crc_pkg::crc_wr_t  wr,
    output logic              pipe_busy
);

    logic signed [crc_pkg::MUL_W-1:0]  mul_op;
    logic signed [crc_pkg::PROD_W-1:0] mul_prod;
    logic [crc_pkg::SQ_W-1:0]          mul_sq;

    logic [crc_pkg::SQ_W-1:0] cx2_reg;
    logic [crc_pkg::SQ_W-1:0] cy2_reg;
    logic [crc_pkg::SQ_W-1:0] outer_reg;
    logic [crc_pkg::SQ_W-1:0] inner_reg;
    logic                     use_inner_reg;

    logic [crc_pkg::SQ_W-1:0]          dx2_reg;
    logic [crc_pkg::SQ_W-1:0]          dy2_reg;
    logic signed [crc_pkg::STEP_W-1:0] tx_reg;
    logic signed [crc_pkg::STEP_W-1:0] ty_reg;
    logic signed [crc_pkg::STEP_W-1:0] tx0;
    logic signed [crc_pkg::STEP_W-1:0] ty0;
    logic signed [crc_pkg::STEP_W-1:0] cx_ext;
    logic signed [crc_pkg::STEP_W-1:0] cy_ext;
    logic [crc_pkg::SQ_W-1:0]          dx2_next;
    logic [crc_pkg::SQ_W-1:0]          dy2_next;

    logic                       v1_reg;
    logic [crc_pkg::SQ_W-1:0]   d2_reg;
    logic [crc_pkg::ADDR_W-1:0] addr1_reg;
    logic [crc_pkg::CHAR_W-1:0] char1_reg;
    logic                       fill1_reg;
    logic                       in_disc;

    // shared squaring multiplier operand
    always_comb
    begin
        case (ctl.mul_sel)
            crc_pkg::MUL_CX: mul_op = {req.center_x[crc_pkg::COORD_W-1], req.center_x};
            crc_pkg::MUL_CY: mul_op = {req.center_y[crc_pkg::COORD_W-1], req.center_y};
            crc_pkg::MUL_R:  mul_op = {req.radius[crc_pkg::COORD_W-1], req.radius};
            default:         mul_op = {req.radius[crc_pkg::COORD_W-1], req.radius}
                                      - crc_pkg::MUL_W'(crc_pkg::UNIT);
        endcase
    end

    assign mul_prod = mul_op * mul_op;
    assign mul_sq   = mul_prod[crc_pkg::SQ_W-1:0];

    // setup squares, one per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            case (ctl.mul_sel)
                crc_pkg::MUL_CX: cx2_reg   <= mul_sq;
                crc_pkg::MUL_CY: cy2_reg   <= mul_sq;
                crc_pkg::MUL_R:  outer_reg <= mul_sq;
                default:         inner_reg <= mul_sq;
            endcase
        end
    end

    // first step terms: (d - 1)^2 = d^2 + (1 - 2d), d in 1/256 units, terms in 1/65536 units
    assign cx_ext = {{(crc_pkg::STEP_W-crc_pkg::COORD_W){req.center_x[crc_pkg::COORD_W-1]}},
                     req.center_x};
    assign cy_ext = {{(crc_pkg::STEP_W-crc_pkg::COORD_W){req.center_y[crc_pkg::COORD_W-1]}},
                     req.center_y};
    assign tx0 = crc_pkg::STEP_W'(crc_pkg::SQ_STEP0) - (cx_ext <<< (crc_pkg::FRAC_W + 1));
    assign ty0 = crc_pkg::STEP_W'(crc_pkg::SQ_STEP0) - (cy_ext <<< (crc_pkg::FRAC_W + 1));

    assign dx2_next = dx2_reg + {{(crc_pkg::SQ_W-crc_pkg::STEP_W){tx_reg[crc_pkg::STEP_W-1]}},
                                 tx_reg};
    assign dy2_next = dy2_reg + {{(crc_pkg::SQ_W-crc_pkg::STEP_W){ty_reg[crc_pkg::STEP_W-1]}},
                                 ty_reg};

    // incremental squared offsets along the scan
    always_ff @(posedge clk)
    begin
        if (ctl.scan_init)
        begin
            dx2_reg       <= cx2_reg;
            tx_reg        <= tx0;
            dy2_reg       <= cy2_reg;
            ty_reg        <= ty0;
            use_inner_reg <= req.outline_only
                             && (req.radius[crc_pkg::COORD_W-2:crc_pkg::FRAC_W] != '0);
        end
        else if (ctl.row_step)
        begin
            dx2_reg <= cx2_reg;
            tx_reg  <= tx0;
            dy2_reg <= dy2_next;
            ty_reg  <= ty_reg + crc_pkg::STEP_W'(crc_pkg::SQ_STEP_INC);
        end
        else if (ctl.col_step)
        begin
            dx2_reg <= dx2_next;
            tx_reg  <= tx_reg + crc_pkg::STEP_W'(crc_pkg::SQ_STEP_INC);
        end
    end

    // stage one valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.emit;
        end
    end

    // stage one payload: summed squared distance, cell address, paint character and fill flag
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            d2_reg    <= dx2_reg + dy2_reg;
            addr1_reg <= {ctl.row, ctl.col};
            char1_reg <= ctl.paint_char;
            fill1_reg <= ctl.fill_all;
        end
    end

    // disc test, with the inner ring cut in outline mode for radii of one unit or more
    assign in_disc = (d2_reg <= outer_reg) && !(use_inner_reg && (d2_reg <= inner_reg));

    assign wr.we     = v1_reg && (fill1_reg || in_disc);
    assign wr.addr   = addr1_reg;
    assign wr.data   = char1_reg;
    assign pipe_busy = v1_reg;

endmodule

### design/crc_seq.sv
// sequencer: request capture, setup steps, raster scan counters,
// canvas read and result strobe
// depends on crc_pkg
module crc_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  crc_pkg::crc_req_t           req,
    input  crc_pkg::crc_cfg_t           cfg,
    input  logic                        pipe_busy,
    input  logic [crc_pkg::CHAR_W-1:0]  rd_data,
    output logic                        busy,
    output logic                        done,
    output crc_pkg::crc_rsp_t           rsp,
    output crc_pkg::crc_ctl_t           ctl,
    output crc_pkg::crc_req_t           req_q,
    output logic                        rd_en,
    output logic [crc_pkg::ADDR_W-1:0]  rd_addr
);

    crc_pkg::crc_state_t state_reg;
    crc_pkg::crc_state_t state_next;

    crc_pkg::crc_req_t          req_reg;
    logic [crc_pkg::SIDE_W-1:0] col_reg;
    logic [crc_pkg::SIDE_W-1:0] col_next;
    logic [crc_pkg::SIDE_W-1:0] row_reg;
    logic [crc_pkg::SIDE_W-1:0] row_next;
    logic [crc_pkg::SIDE_W-1:0] last_col_reg;
    logic [crc_pkg::SIDE_W-1:0] last_row_reg;
    logic [crc_pkg::ADDR_W-1:0] rd_addr_reg;
    logic                       done_reg;
    logic                       done_next;
    crc_pkg::crc_rsp_t          rsp_reg;
    crc_pkg::crc_rsp_t          rsp_next;

    logic [crc_pkg::SIZE_W-1:0] w_used;
    logic [crc_pkg::SIZE_W-1:0] h_used;
    logic                       empty;
    logic                       rd_oob;
    logic                       bad_radius;
    logic                       accept;
    logic                       at_last_col;
    logic                       at_end;

    assign w_used     = crc_pkg::clamp_side(cfg.canvas_width);
    assign h_used     = crc_pkg::clamp_side(cfg.canvas_height);
    assign empty      = (w_used == '0) || (h_used == '0);
    assign rd_oob     = (crc_pkg::SIZE_W'(req.read_col) >= w_used)
                        || (crc_pkg::SIZE_W'(req.read_row) >= h_used);
    assign bad_radius = req.radius[crc_pkg::COORD_W-1] || (req.radius == '0);
    assign accept     = start && (state_reg == crc_pkg::ST_IDLE);
    assign at_last_col = (col_reg == last_col_reg);
    assign at_end      = at_last_col && (row_reg == last_row_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (req.kind)
                        crc_pkg::KIND_CLEAR:
                            state_next = empty ? crc_pkg::ST_IDLE : crc_pkg::ST_SCAN;
                        crc_pkg::KIND_DRAW:
                            state_next = (bad_radius || empty) ? crc_pkg::ST_IDLE
                                                               : crc_pkg::ST_MUL_CX;
                        crc_pkg::KIND_READ:
                            state_next = rd_oob ? crc_pkg::ST_IDLE : crc_pkg::ST_READ;
                        default:
                            state_next = crc_pkg::ST_IDLE;
                    endcase
                end
            end
            crc_pkg::ST_MUL_CX:    state_next = crc_pkg::ST_MUL_CY;
            crc_pkg::ST_MUL_CY:    state_next = crc_pkg::ST_MUL_R;
            crc_pkg::ST_MUL_R:     state_next = crc_pkg::ST_MUL_RI;
            crc_pkg::ST_MUL_RI:    state_next = crc_pkg::ST_SCAN;
            crc_pkg::ST_SCAN:
            begin
                if (at_end)
                begin
                    state_next = crc_pkg::ST_DRAIN;
                end
            end
            crc_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = crc_pkg::ST_IDLE;
                end
            end
            crc_pkg::ST_READ:      state_next = crc_pkg::ST_READ_DONE;
            crc_pkg::ST_READ_DONE: state_next = crc_pkg::ST_IDLE;
            default:               state_next = crc_pkg::ST_IDLE;
        endcase
    end

    // outputs, counters and result
    always_comb
    begin
        done_next     = 1'b0;
        rsp_next      = '0;
        col_next      = col_reg;
        row_next      = row_reg;
        ctl           = '0;
        ctl.mul_sel   = crc_pkg::MUL_CX;
        ctl.col       = col_reg;
        ctl.row       = row_reg;
        ctl.fill_all  = (req_reg.kind == crc_pkg::KIND_CLEAR);
        ctl.paint_char = ctl.fill_all ? cfg.background_char : req_reg.paint_char;
        unique case (state_reg)
            crc_pkg::ST_IDLE:
            begin
                col_next = '0;
                row_next = '0;
                if (start)
                begin
                    case (req.kind)
                        crc_pkg::KIND_CLEAR:
                            done_next = empty;
                        crc_pkg::KIND_DRAW:
                        begin
                            done_next = bad_radius || empty;
                            if (bad_radius)
                            begin
                                rsp_next.status = crc_pkg::STAT_RADIUS;
                            end
                        end
                        crc_pkg::KIND_READ:
                        begin
                            done_next = rd_oob;
                            if (rd_oob)
                            begin
                                rsp_next.status = crc_pkg::STAT_RANGE;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            crc_pkg::ST_MUL_CX:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = crc_pkg::MUL_CX;
            end
            crc_pkg::ST_MUL_CY:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = crc_pkg::MUL_CY;
            end
            crc_pkg::ST_MUL_R:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = crc_pkg::MUL_R;
            end
            crc_pkg::ST_MUL_RI:
            begin
                ctl.mul_en    = 1'b1;
                ctl.mul_sel   = crc_pkg::MUL_RI;
                ctl.scan_init = 1'b1;
            end
            crc_pkg::ST_SCAN:
            begin
                ctl.emit     = 1'b1;
                ctl.col_step = !at_last_col;
                ctl.row_step = at_last_col;
                if (at_last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            crc_pkg::ST_DRAIN:
            begin
                done_next = !pipe_busy;
            end
            crc_pkg::ST_READ:
            begin
            end
            crc_pkg::ST_READ_DONE:
            begin
                done_next          = 1'b1;
                rsp_next.cell_char = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req;
            last_col_reg <= crc_pkg::SIDE_W'(w_used - 1'b1);
            last_row_reg <= crc_pkg::SIDE_W'(h_used - 1'b1);
            rd_addr_reg  <= {crc_pkg::SIDE_W'(req.read_row), crc_pkg::SIDE_W'(req.read_col)};
        end
        rsp_reg <= rsp_next;
    end

    assign busy    = (state_reg != crc_pkg::ST_IDLE);
    assign done    = done_reg;
    assign rsp     = rsp_reg;
    assign req_q   = req_reg;
    assign rd_en   = (state_reg == crc_pkg::ST_READ);
    assign rd_addr = rd_addr_reg;

endmodule

### design/circle_raster_canvas.sv
// circle raster canvas top level: configuration registers, sequencer,
// distance unit and canvas memory; depends on crc_pkg and the assert header
//
//  channel   signals                        handshake
//  request   start, req, busy               taken when start && !busy
//  result    done, rsp                      one-cycle strobe, no back pressure
//  config    cfg_we, cfg_idx, cfg_data      taken when cfg_we, no wait
//
// clears and draws scan the canvas one cell per cycle, with no stall,
// writing painted cells through the single memory write port; before the
// scan a draw squares the centre coordinates, the radius and the radius
// less one unit on one shared multiplier. a read goes through the
// registered memory read; errors, empty canvases and the unused kind answer
// in the cycle after the request is taken. reset clears control state only;
// canvas contents stay undefined until a clear. one request is in flight at a time.
module circle_raster_canvas (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  crc_pkg::crc_req_t               req,
    output logic                            busy,
    output logic                            done,
    output crc_pkg::crc_rsp_t               rsp,
    input  logic                            cfg_we,
    input  logic [crc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [crc_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "circle_raster_canvas_assert.svh"

    crc_pkg::crc_cfg_t          cfg_reg;
    crc_pkg::crc_ctl_t          ctl;
    crc_pkg::crc_req_t          req_q;
    crc_pkg::crc_wr_t           wr;
    logic                       pipe_busy;
    logic                       rd_en;
    logic [crc_pkg::ADDR_W-1:0] rd_addr;
    logic [crc_pkg::CHAR_W-1:0] rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width    <= crc_pkg::RESET_WIDTH;
            cfg_reg.canvas_height   <= crc_pkg::RESET_HEIGHT;
            cfg_reg.background_char <= crc_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                crc_pkg::REG_WIDTH:  cfg_reg.canvas_width  <= cfg_data;
                crc_pkg::REG_HEIGHT: cfg_reg.canvas_height <= cfg_data;
                crc_pkg::REG_BG:
                    cfg_reg.background_char <= cfg_data[crc_pkg::CHAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    crc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg       (cfg_reg),
        .pipe_busy (pipe_busy),
        .rd_data   (rd_data),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .ctl       (ctl),
        .req_q     (req_q),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // distance test and write request
    crc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req_q),
        .wr        (wr),
        .pipe_busy (pipe_busy)
    );

    // canvas storage
    crc_canvas_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // checks
    `CRC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    `CRC_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done,
        "accepted request neither running nor answered")
    `CRC_ASSERT_NOW(a_write_busy, wr.we, busy, "canvas write outside a request")
    `CRC_ASSERT_NOW(a_error_char, done && (rsp.status != crc_pkg::STAT_OK),
        rsp.cell_char == '0, "error result carries a character")

endmodule

### sim/circle_raster_canvas_tb.sv
// self-checking testbench of the circle raster canvas: clears, circle draws and cell reads
// checked against a behavioral copy of the canvas; depends on crc_pkg and circle_raster_canvas
`timescale 1ns / 1ps

module circle_raster_canvas_tb;

    // kind code with no operation behind it
    localparam logic [crc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // longest stretch with no request taken and no result seen
    localparam int unsigned QUIET_LIMIT = 1_000_000;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           start    = 1'b0;
    crc_pkg::crc_req_t              req      = '0;
    logic                           busy;
    logic                           done;
    crc_pkg::crc_rsp_t              rsp;
    logic                           cfg_we   = 1'b0;
    logic [crc_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [crc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // register copies, canvas copy and the two fifos
    logic [crc_pkg::SIZE_W-1:0] reg_width  = crc_pkg::RESET_WIDTH;
    logic [crc_pkg::SIZE_W-1:0] reg_height = crc_pkg::RESET_HEIGHT;
    logic [crc_pkg::CHAR_W-1:0] reg_bg     = crc_pkg::RESET_BG;
    logic [crc_pkg::CHAR_W-1:0] canvas_copy [crc_pkg::DEPTH];
    crc_pkg::crc_req_t          request_fifo [$];
    crc_pkg::crc_rsp_t          answer_fifo [$];

    bit                sender_idles = 1'b1;
    int unsigned       hold_off     = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       fail_count   = 0;
    crc_pkg::crc_rsp_t head;

    circle_raster_canvas i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // apply one request to the canvas copy and queue the answer it gives
    function automatic void rasterize_request(input crc_pkg::crc_req_t r);
        crc_pkg::crc_rsp_t ans;
        int unsigned       w_use, h_use, col, row;
        longint            cx, cy, rad, outer, inner2, dx, dy, dy2, d2;
        bit                use_inner;
        ans   = '0;
        w_use = (reg_width > crc_pkg::MAX_SIDE) ? crc_pkg::MAX_SIDE : reg_width;
        h_use = (reg_height > crc_pkg::MAX_SIDE) ? crc_pkg::MAX_SIDE : reg_height;
        case (r.kind)
            crc_pkg::KIND_CLEAR:
            begin
                for (row = 0; row < h_use; row++)
                    for (col = 0; col < w_use; col++)
                        canvas_copy[row * crc_pkg::MAX_SIDE + col] = reg_bg;
            end
            crc_pkg::KIND_DRAW:
            begin
                cx  = $signed(r.center_x);
                cy  = $signed(r.center_y);
                rad = $signed(r.radius);
                if (rad <= 0)
                    ans.status = crc_pkg::STAT_RADIUS;
                else
                begin
                    // squared distances against squared radii, ring only from one unit up
                    outer     = rad * rad;
                    use_inner = r.outline_only && (rad >= crc_pkg::UNIT);
                    inner2    = (rad - crc_pkg::UNIT) * (rad - crc_pkg::UNIT);
                    for (row = 0; row < h_use; row++)
                    begin
                        dy  = cy - longint'(row) * crc_pkg::UNIT;
                        dy2 = dy * dy;
                        for (col = 0; col < w_use; col++)
                        begin
                            dx = cx - longint'(col) * crc_pkg::UNIT;
                            d2 = dx * dx + dy2;
                            if (d2 <= outer && !(use_inner && d2 <= inner2))
                                canvas_copy[row * crc_pkg::MAX_SIDE + col] = r.paint_char;
                        end
                    end
                end
            end
            crc_pkg::KIND_READ:
            begin
                if (r.read_col >= w_use || r.read_row >= h_use)
                    ans.status = crc_pkg::STAT_RANGE;
                else
                    ans.cell_char = canvas_copy[int'(r.read_row) * crc_pkg::MAX_SIDE
                                                + int'(r.read_col)];
            end
            default: ;
        endcase
        answer_fifo.push_back(ans);
    endfunction

    function automatic crc_pkg::crc_req_t make_item(
        input logic [crc_pkg::KIND_W-1:0] kind, input int cx, input int cy, input int rad,
        input int outline, input logic [crc_pkg::CHAR_W-1:0] pc, input int col,
        input int row);
        crc_pkg::crc_req_t r;
        r.kind         = kind;
        r.center_x     = crc_pkg::COORD_W'(cx);
        r.center_y     = crc_pkg::COORD_W'(cy);
        r.radius       = crc_pkg::COORD_W'(rad);
        r.outline_only = 1'(outline);
        r.paint_char   = pc;
        r.read_col     = crc_pkg::READ_W'(col);
        r.read_row     = crc_pkg::READ_W'(row);
        return r;
    endfunction

    // random request, fields the kind does not use stay random
    function automatic crc_pkg::crc_req_t random_request(input bit reads_only);
        crc_pkg::crc_req_t r;
        int unsigned       w_use, h_use, span, pick;
        w_use          = (reg_width > crc_pkg::MAX_SIDE) ? crc_pkg::MAX_SIDE : reg_width;
        h_use          = (reg_height > crc_pkg::MAX_SIDE) ? crc_pkg::MAX_SIDE : reg_height;
        span           = ((w_use > h_use) ? w_use : h_use) + 2;
        r.center_x     = crc_pkg::COORD_W'($urandom);
        r.center_y     = crc_pkg::COORD_W'($urandom);
        r.radius       = crc_pkg::COORD_W'($urandom);
        r.outline_only = 1'($urandom_range(0, 1));
        r.paint_char   = crc_pkg::CHAR_W'($urandom);
        r.read_col     = crc_pkg::READ_W'($urandom);
        r.read_row     = crc_pkg::READ_W'($urandom);
        pick           = reads_only ? 99 : $urandom_range(0, 99);
        if (pick < 12)
            r.kind = crc_pkg::KIND_CLEAR;
        else if (pick < 55)
        begin
            r.kind = crc_pkg::KIND_DRAW;
            case ($urandom_range(0, 9))
                0: ;
                1: r.radius = crc_pkg::COORD_W'(-int'($urandom_range(0, 2048)));
                default:
                begin
                    // centre on or near the canvas, radius up to half the span
                    r.center_x = crc_pkg::COORD_W'(
                        int'($urandom_range(0, span * crc_pkg::UNIT)) - crc_pkg::UNIT);
                    r.center_y = crc_pkg::COORD_W'(
                        int'($urandom_range(0, span * crc_pkg::UNIT)) - crc_pkg::UNIT);
                    if ($urandom_range(0, 3) == 0)
                        r.radius = crc_pkg::COORD_W'($urandom_range(1, 2 * crc_pkg::UNIT));
                    else
                        r.radius = crc_pkg::COORD_W'(
                            $urandom_range(1, span * crc_pkg::UNIT / 2));
                    // whole-unit values put cells exactly on the boundaries
                    if ($urandom_range(0, 2) == 0)
                    begin
                        r.center_x[crc_pkg::FRAC_W-1:0] = '0;
                        r.center_y[crc_pkg::FRAC_W-1:0] = '0;
                        r.radius[crc_pkg::FRAC_W-1:0]   = '0;
                    end
                end
            endcase
        end
        else
        begin
            r.kind = crc_pkg::KIND_READ;
            if (w_use != 0 && h_use != 0 && $urandom_range(0, 5) != 0)
            begin
                r.read_col = crc_pkg::READ_W'($urandom_range(0, w_use - 1));
                r.read_row = crc_pkg::READ_W'($urandom_range(0, h_use - 1));
            end
        end
        return r;
    endfunction

    // driver: one request at a time, held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            req      <= '0;
            hold_off <= 0;
        end
        else
        begin
            if (start && !busy)
                rasterize_request(req);
            if (!start || !busy)
            begin
                if (hold_off != 0)
                begin
                    hold_off <= hold_off - 1;
                    start    <= 1'b0;
                end
                else if (request_fifo.size() != 0)
                begin
                    req   <= request_fifo.pop_front();
                    start <= 1'b1;
                    if (sender_idles && $urandom_range(0, 3) == 0)
                        hold_off <= $urandom_range(1, 7);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each result strobe with the oldest answer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answer_fifo.size() == 0)
            begin
                $error("result with no request outstanding: cell_char %0d status %0d",
                       rsp.cell_char, rsp.status);
                fail_count++;
            end
            else
            begin
                head = answer_fifo.pop_front();
                if (rsp.cell_char !== head.cell_char)
                begin
                    $error("cell_char expected %0d actual %0d", head.cell_char, rsp.cell_char);
                    fail_count++;
                end
                if (rsp.status !== head.status)
                begin
                    $error("status expected %0d actual %0d", head.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // wait until every request is taken and answered
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (request_fifo.size() != 0 || answer_fifo.size() != 0 || start);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input int unsigned w, input int unsigned h,
                                input int unsigned bg);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= crc_pkg::REG_WIDTH;
        cfg_data <= crc_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_idx  <= crc_pkg::REG_HEIGHT;
        cfg_data <= crc_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_idx  <= crc_pkg::REG_BG;
        cfg_data <= crc_pkg::CFG_DATA_W'(bg);
        @(posedge clk);
        cfg_we   <= 1'b0;
        reg_width  = crc_pkg::SIZE_W'(w);
        reg_height = crc_pkg::SIZE_W'(h);
        reg_bg     = crc_pkg::CHAR_W'(bg);
        @(negedge clk);
    endtask

    // new canvas setting, a clear first so every cell in use is defined
    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned bg, input int n);
        wait_until_idle();
        write_config(w, h, bg);
        request_fifo.push_back(make_item(crc_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 0));
        repeat (n) request_fifo.push_back(random_request(1'b0));
    endtask

    initial
    begin
        crc_pkg::crc_req_t odd;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting, one cell
        request_fifo.push_back(make_item(crc_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 1, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 0, 0, 1, 1, 8'h41, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 0, 0));
        odd      = random_request(1'b0);
        odd.kind = KIND_UNUSED;
        request_fifo.push_back(odd);
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 524287, -524288, -524288, 0,
                                         8'h42, 0, 0));

        // small canvas: fills, rings, boundary ties, extreme coordinates
        wait_until_idle();
        write_config(9, 7, 'h2E);
        request_fifo.push_back(make_item(crc_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 4 * crc_pkg::UNIT,
                                         3 * crc_pkg::UNIT, 3 * crc_pkg::UNIT, 0, 8'hFF,
                                         0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 4 * crc_pkg::UNIT + 128,
                                         3 * crc_pkg::UNIT - 77, 2 * crc_pkg::UNIT + 128, 1,
                                         8'h00, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 0, 0, crc_pkg::UNIT, 1, 8'h55,
                                         0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 8 * crc_pkg::UNIT,
                                         6 * crc_pkg::UNIT, crc_pkg::UNIT, 0, 8'hAA, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 2 * crc_pkg::UNIT + 1,
                                         5 * crc_pkg::UNIT, crc_pkg::UNIT - 1, 1, 8'h11,
                                         0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 0, 0, 524287, 1, 8'h33, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, -524288, 524287, 524287, 0,
                                         8'h99, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, crc_pkg::UNIT, crc_pkg::UNIT, 0,
                                         0, 8'h66, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 8, 6));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 4, 3));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 9, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 0, 7));
        request_fifo.push_back(make_item(crc_pkg::KIND_READ, 0, 0, 0, 0, 8'h00, 511, 511));

        // random phases over several canvas settings
        run_phase(16, 12, $urandom_range(1, 254), 28);
        run_phase(0, 0, 0, 6);
        run_phase(512, 3, 'hFF, 10);
        run_phase(1, 512, 1, 10);

        // oversized registers clamp to the full canvas, keep draws few
        wait_until_idle();
        write_config(1023, 1023, 'h80);
        request_fifo.push_back(make_item(crc_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 0));
        request_fifo.push_back(make_item(crc_pkg::KIND_DRAW, 300 * crc_pkg::UNIT + 91,
                                         200 * crc_pkg::UNIT - 13, 150 * crc_pkg::UNIT + 7,
                                         int'($urandom_range(0, 1)),
                                         crc_pkg::CHAR_W'($urandom_range(0, 255)), 0, 0));
        repeat (9) request_fifo.push_back(random_request(1'b1));

        // closing stretch with the sender never idle
        wait_until_idle();
        sender_idles = 1'b0;
        run_phase(23, 17, 0, 30);

        wait_until_idle();
        if (fail_count == 0 && answer_fifo.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
